// ===== hdl/dcm_pkg.sv =====
package dcm_pkg;

   localparam int BlockWidth = 64;
   localparam int HalfWidth  = 32;
   localparam int KeyWidth   = 64;
   localparam int CdWidth    = 56;
   localparam int SubWidth   = 48;
   localparam int Rounds     = 16;
   localparam int RoundBits  = $clog2(Rounds);

   typedef logic [0:0] csr_index_type;
   localparam csr_index_type CSR_CIPHER_KEY   = 1'b0;
   localparam csr_index_type CSR_DECRYPT_MODE = 1'b1;

   localparam logic FUNC_COUNTER = 1'b0;
   localparam logic FUNC_DIRECT  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   localparam logic [6:0] IP_TAB [64] = '{
      7'd58,7'd50,7'd42,7'd34,7'd26,7'd18,7'd10,7'd2, 7'd60,7'd52,7'd44,7'd36,7'd28,7'd20,7'd12,7'd4,
      7'd62,7'd54,7'd46,7'd38,7'd30,7'd22,7'd14,7'd6, 7'd64,7'd56,7'd48,7'd40,7'd32,7'd24,7'd16,7'd8,
      7'd57,7'd49,7'd41,7'd33,7'd25,7'd17,7'd9,7'd1,  7'd59,7'd51,7'd43,7'd35,7'd27,7'd19,7'd11,7'd3,
      7'd61,7'd53,7'd45,7'd37,7'd29,7'd21,7'd13,7'd5, 7'd63,7'd55,7'd47,7'd39,7'd31,7'd23,7'd15,7'd7
   };

   localparam logic [6:0] FP_TAB [64] = '{
      7'd40,7'd8,7'd48,7'd16,7'd56,7'd24,7'd64,7'd32, 7'd39,7'd7,7'd47,7'd15,7'd55,7'd23,7'd63,7'd31,
      7'd38,7'd6,7'd46,7'd14,7'd54,7'd22,7'd62,7'd30, 7'd37,7'd5,7'd45,7'd13,7'd53,7'd21,7'd61,7'd29,
      7'd36,7'd4,7'd44,7'd12,7'd52,7'd20,7'd60,7'd28, 7'd35,7'd3,7'd43,7'd11,7'd51,7'd19,7'd59,7'd27,
      7'd34,7'd2,7'd42,7'd10,7'd50,7'd18,7'd58,7'd26, 7'd33,7'd1,7'd41,7'd9,7'd49,7'd17,7'd57,7'd25
   };

   localparam logic [6:0] PC1_TAB [56] = '{
      7'd57,7'd49,7'd41,7'd33,7'd25,7'd17,7'd9, 7'd1,7'd58,7'd50,7'd42,7'd34,7'd26,7'd18,
      7'd10,7'd2,7'd59,7'd51,7'd43,7'd35,7'd27, 7'd19,7'd11,7'd3,7'd60,7'd52,7'd44,7'd36,
      7'd63,7'd55,7'd47,7'd39,7'd31,7'd23,7'd15, 7'd7,7'd62,7'd54,7'd46,7'd38,7'd30,7'd22,
      7'd14,7'd6,7'd61,7'd53,7'd45,7'd37,7'd29, 7'd21,7'd13,7'd5,7'd28,7'd20,7'd12,7'd4
   };

   localparam logic [5:0] PC2_TAB [48] = '{
      6'd14,6'd17,6'd11,6'd24,6'd1,6'd5, 6'd3,6'd28,6'd15,6'd6,6'd21,6'd10,
      6'd23,6'd19,6'd12,6'd4,6'd26,6'd8, 6'd16,6'd7,6'd27,6'd20,6'd13,6'd2,
      6'd41,6'd52,6'd31,6'd37,6'd47,6'd55, 6'd30,6'd40,6'd51,6'd45,6'd33,6'd48,
      6'd44,6'd49,6'd39,6'd56,6'd34,6'd53, 6'd46,6'd42,6'd50,6'd36,6'd29,6'd32
   };

   // set where the schedule shifts by two
   localparam logic [Rounds-1:0] ROT_TWO = 16'b0111_1110_1111_1100;

   localparam logic [31:0] SP_TAB [8][64] = '{
      '{32'h00808200,32'h00000000,32'h00008000,32'h00808202,32'h00808002,32'h00008202,32'h00000002,32'h00008000,
        32'h00000200,32'h00808200,32'h00808202,32'h00000200,32'h00800202,32'h00808002,32'h00800000,32'h00000002,
        32'h00000202,32'h00800200,32'h00800200,32'h00008200,32'h00008200,32'h00808000,32'h00808000,32'h00800202,
        32'h00008002,32'h00800002,32'h00800002,32'h00008002,32'h00000000,32'h00000202,32'h00008202,32'h00800000,
        32'h00008000,32'h00808202,32'h00000002,32'h00808000,32'h00808200,32'h00800000,32'h00800000,32'h00000200,
        32'h00808002,32'h00008000,32'h00008200,32'h00800002,32'h00000200,32'h00000002,32'h00800202,32'h00008202,
        32'h00808202,32'h00008002,32'h00808000,32'h00800202,32'h00800002,32'h00000202,32'h00008202,32'h00808200,
        32'h00000202,32'h00800200,32'h00800200,32'h00000000,32'h00008002,32'h00008200,32'h00000000,32'h00808002},
      '{32'h40084010,32'h40004000,32'h00004000,32'h00084010,32'h00080000,32'h00000010,32'h40080010,32'h40004010,
        32'h40000010,32'h40084010,32'h40084000,32'h40000000,32'h40004000,32'h00080000,32'h00000010,32'h40080010,
        32'h00084000,32'h00080010,32'h40004010,32'h00000000,32'h40000000,32'h00004000,32'h00084010,32'h40080000,
        32'h00080010,32'h40000010,32'h00000000,32'h00084000,32'h00004010,32'h40084000,32'h40080000,32'h00004010,
        32'h00000000,32'h00084010,32'h40080010,32'h00080000,32'h40004010,32'h40080000,32'h40084000,32'h00004000,
        32'h40080000,32'h40004000,32'h00000010,32'h40084010,32'h00084010,32'h00000010,32'h00004000,32'h40000000,
        32'h00004010,32'h40084000,32'h00080000,32'h40000010,32'h00080010,32'h40004010,32'h40000010,32'h00080010,
        32'h00084000,32'h00000000,32'h40004000,32'h00004010,32'h40000000,32'h40080010,32'h40084010,32'h00084000},
      '{32'h00000104,32'h04010100,32'h00000000,32'h04010004,32'h04000100,32'h00000000,32'h00010104,32'h04000100,
        32'h00010004,32'h04000004,32'h04000004,32'h00010000,32'h04010104,32'h00010004,32'h04010000,32'h00000104,
        32'h04000000,32'h00000004,32'h04010100,32'h00000100,32'h00010100,32'h04010000,32'h04010004,32'h00010104,
        32'h04000104,32'h00010100,32'h00010000,32'h04000104,32'h00000004,32'h04010104,32'h00000100,32'h04000000,
        32'h04010100,32'h04000000,32'h00010004,32'h00000104,32'h00010000,32'h04010100,32'h04000100,32'h00000000,
        32'h00000100,32'h00010004,32'h04010104,32'h04000100,32'h04000004,32'h00000100,32'h00000000,32'h04010004,
        32'h04000104,32'h00010000,32'h04000000,32'h04010104,32'h00000004,32'h00010104,32'h00010100,32'h04000004,
        32'h04010000,32'h04000104,32'h00000104,32'h04010000,32'h00010104,32'h00000004,32'h04010004,32'h00010100},
      '{32'h80401000,32'h80001040,32'h80001040,32'h00000040,32'h00401040,32'h80400040,32'h80400000,32'h80001000,
        32'h00000000,32'h00401000,32'h00401000,32'h80401040,32'h80000040,32'h00000000,32'h00400040,32'h80400000,
        32'h80000000,32'h00001000,32'h00400000,32'h80401000,32'h00000040,32'h00400000,32'h80001000,32'h00001040,
        32'h80400040,32'h80000000,32'h00001040,32'h00400040,32'h00001000,32'h00401040,32'h80401040,32'h80000040,
        32'h00400040,32'h80400000,32'h00401000,32'h80401040,32'h80000040,32'h00000000,32'h00000000,32'h00401000,
        32'h00001040,32'h00400040,32'h80400040,32'h80000000,32'h80401000,32'h80001040,32'h80001040,32'h00000040,
        32'h80401040,32'h80000040,32'h80000000,32'h00001000,32'h80400000,32'h80001000,32'h00401040,32'h80400040,
        32'h80001000,32'h00001040,32'h00400000,32'h80401000,32'h00000040,32'h00400000,32'h00001000,32'h00401040},
      '{32'h00000080,32'h01040080,32'h01040000,32'h21000080,32'h00040000,32'h00000080,32'h20000000,32'h01040000,
        32'h20040080,32'h00040000,32'h01000080,32'h20040080,32'h21000080,32'h21040000,32'h00040080,32'h20000000,
        32'h01000000,32'h20040000,32'h20040000,32'h00000000,32'h20000080,32'h21040080,32'h21040080,32'h01000080,
        32'h21040000,32'h20000080,32'h00000000,32'h21000000,32'h01040080,32'h01000000,32'h21000000,32'h00040080,
        32'h00040000,32'h21000080,32'h00000080,32'h01000000,32'h20000000,32'h01040000,32'h21000080,32'h20040080,
        32'h01000080,32'h20000000,32'h21040000,32'h01040080,32'h20040080,32'h00000080,32'h01000000,32'h21040000,
        32'h21040080,32'h00040080,32'h21000000,32'h21040080,32'h01040000,32'h00000000,32'h20040000,32'h21000000,
        32'h00040080,32'h01000080,32'h20000080,32'h00040000,32'h00000000,32'h20040000,32'h01040080,32'h20000080},
      '{32'h10000008,32'h10200000,32'h00002000,32'h10202008,32'h10200000,32'h00000008,32'h10202008,32'h00200000,
        32'h10002000,32'h00202008,32'h00200000,32'h10000008,32'h00200008,32'h10002000,32'h10000000,32'h00002008,
        32'h00000000,32'h00200008,32'h10002008,32'h00002000,32'h00202000,32'h10002008,32'h00000008,32'h10200008,
        32'h10200008,32'h00000000,32'h00202008,32'h10202000,32'h00002008,32'h00202000,32'h10202000,32'h10000000,
        32'h10002000,32'h00000008,32'h10200008,32'h00202000,32'h10202008,32'h00200000,32'h00002008,32'h10000008,
        32'h00200000,32'h10002000,32'h10000000,32'h00002008,32'h10000008,32'h10202008,32'h00202000,32'h10200000,
        32'h00202008,32'h10202000,32'h00000000,32'h10200008,32'h00000008,32'h00002000,32'h10200000,32'h00202008,
        32'h00002000,32'h00200008,32'h10002008,32'h00000000,32'h10202000,32'h10000000,32'h00200008,32'h10002008},
      '{32'h00100000,32'h02100001,32'h02000401,32'h00000000,32'h00000400,32'h02000401,32'h00100401,32'h02100400,
        32'h02100401,32'h00100000,32'h00000000,32'h02000001,32'h00000001,32'h02000000,32'h02100001,32'h00000401,
        32'h02000400,32'h00100401,32'h00100001,32'h02000400,32'h02000001,32'h02100000,32'h02100400,32'h00100001,
        32'h02100000,32'h00000400,32'h00000401,32'h02100401,32'h00100400,32'h00000001,32'h02000000,32'h00100400,
        32'h02000000,32'h00100400,32'h00100000,32'h02000401,32'h02000401,32'h02100001,32'h02100001,32'h00000001,
        32'h00100001,32'h02000000,32'h02000400,32'h00100000,32'h02100400,32'h00000401,32'h00100401,32'h02100400,
        32'h00000401,32'h02000001,32'h02100401,32'h02100000,32'h00100400,32'h00000000,32'h00000001,32'h02100401,
        32'h00000000,32'h00100401,32'h02100000,32'h00000400,32'h02000001,32'h02000400,32'h00000400,32'h00100001},
      '{32'h08000820,32'h00000800,32'h00020000,32'h08020820,32'h08000000,32'h08000820,32'h00000020,32'h08000000,
        32'h00020020,32'h08020000,32'h08020820,32'h00020800,32'h08020800,32'h00020820,32'h00000800,32'h00000020,
        32'h08020000,32'h08000020,32'h08000800,32'h00000820,32'h00020800,32'h00020020,32'h08020020,32'h08020800,
        32'h00000820,32'h00000000,32'h00000000,32'h08020020,32'h08000020,32'h08000800,32'h00020820,32'h00020000,
        32'h00020820,32'h00020000,32'h08020800,32'h00000800,32'h00000020,32'h08020020,32'h00000800,32'h00020820,
        32'h08000800,32'h00000020,32'h08000020,32'h08020000,32'h08020020,32'h08000000,32'h00020000,32'h08000820,
        32'h00000000,32'h08020820,32'h00020020,32'h08000020,32'h08020000,32'h08000800,32'h08000820,32'h00000000,
        32'h08020820,32'h00020800,32'h00020800,32'h00000820,32'h00000820,32'h00020020,32'h08000000,32'h08020800}
   };

   // table entries number bits from the msb, starting at one
   function automatic logic [BlockWidth-1:0] ip_perm(input logic [BlockWidth-1:0] x);
      logic [BlockWidth-1:0] r;
      r = '0;
      for (int i = 0; i < BlockWidth; i++) begin
         r[BlockWidth-1-i] = x[BlockWidth - int'(IP_TAB[i])];
      end
      return r;
   endfunction

   function automatic logic [BlockWidth-1:0] fp_perm(input logic [BlockWidth-1:0] x);
      logic [BlockWidth-1:0] r;
      r = '0;
      for (int i = 0; i < BlockWidth; i++) begin
         r[BlockWidth-1-i] = x[BlockWidth - int'(FP_TAB[i])];
      end
      return r;
   endfunction

   function automatic logic [CdWidth-1:0] pc1_perm(input logic [KeyWidth-1:0] x);
      logic [CdWidth-1:0] r;
      r = '0;
      for (int i = 0; i < CdWidth; i++) begin
         r[CdWidth-1-i] = x[KeyWidth - int'(PC1_TAB[i])];
      end
      return r;
   endfunction

   function automatic logic [SubWidth-1:0] pc2_perm(input logic [CdWidth-1:0] x);
      logic [SubWidth-1:0] r;
      r = '0;
      for (int i = 0; i < SubWidth; i++) begin
         r[SubWidth-1-i] = x[CdWidth - int'(PC2_TAB[i])];
      end
      return r;
   endfunction

   function automatic logic [CdWidth-1:0] cd_rotl(input logic [CdWidth-1:0] cd,
                                                  input logic two);
      logic [27:0] c;
      logic [27:0] d;
      c = cd[55:28];
      d = cd[27:0];
      if (two) begin
         return {c[25:0], c[27:26], d[25:0], d[27:26]};
      end
      return {c[26:0], c[27], d[26:0], d[27]};
   endfunction

   function automatic logic [CdWidth-1:0] cd_rotr(input logic [CdWidth-1:0] cd,
                                                  input logic two);
      logic [27:0] c;
      logic [27:0] d;
      c = cd[55:28];
      d = cd[27:0];
      if (two) begin
         return {c[1:0], c[27:2], d[1:0], d[27:2]};
      end
      return {c[0], c[27:1], d[0], d[27:1]};
   endfunction

   // expansion, key mix, s-boxes and p
   function automatic logic [HalfWidth-1:0] round_f(input logic [HalfWidth-1:0] r,
                                                    input logic [SubWidth-1:0] k);
      logic [5:0] idx [8];
      logic [HalfWidth-1:0] f;
      idx[0] = {r[0], r[31:27]};
      idx[1] = r[28:23];
      idx[2] = r[24:19];
      idx[3] = r[20:15];
      idx[4] = r[16:11];
      idx[5] = r[12:7];
      idx[6] = r[8:3];
      idx[7] = {r[4:0], r[31]};
      f = '0;
      for (int i = 0; i < 8; i++) begin
         f = f | SP_TAB[i][idx[i] ^ k[SubWidth-1-6*i -: 6]];
      end
      return f;
   endfunction

endpackage

// ===== hdl/des_counter_mode_generator.sv =====
// DES engine (FIPS 46-3) run as a counter-mode block generator. An item with
// req_func low ciphers the internal 64-bit counter and then increments it; an
// item with req_func high ciphers req_block_in. One Feistel round runs per
// clock on a single round unit, with the round keys shifted out of a C/D key
// register alongside. rsp_valid rises once all 16 rounds of an accepted item
// have run. The result holds until it is taken, and the block takes no new
// item until then; it returns to idle before it takes the next one.
// csr index 0 writes the key and clears the counter, index 1 bit 0 selects
// decryption; write them only while the block is idle.
module des_counter_mode_generator
   import dcm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_func,
   input  logic [BlockWidth-1:0] req_block_in,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [BlockWidth-1:0] rsp_block_out,
   input  logic                  csr_we,
   input  csr_index_type         csr_index,
   input  logic [KeyWidth-1:0]   csr_wdata
);

   state_type               state_ff, state_in;
   logic [KeyWidth-1:0]     key_ff;
   logic                    decrypt_ff;
   logic [BlockWidth-1:0]   counter_ff;
   logic [RoundBits-1:0]    round_ff;
   logic [HalfWidth-1:0]    l_ff, r_ff;
   logic [CdWidth-1:0]      cd_ff, cd_in;
   logic [BlockWidth-1:0]   out_ff;

   logic                    req_take;
   logic [BlockWidth-1:0]   blk_in;
   logic [BlockWidth-1:0]   ip_blk;
   logic [CdWidth-1:0]      cd_fwd;
   logic [SubWidth-1:0]     subkey;
   logic [HalfWidth-1:0]    f_out;
   logic                    last_round;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = (state_ff == ST_DONE);
   assign rsp_block_out = out_ff;

   assign blk_in = (req_func == FUNC_DIRECT) ? req_block_in : counter_ff;
   assign ip_blk = ip_perm(blk_in);

   // encrypt shifts left before use, decrypt uses then shifts right
   assign cd_fwd = cd_rotl(cd_ff, ROT_TWO[round_ff]);
   assign subkey = decrypt_ff ? pc2_perm(cd_ff) : pc2_perm(cd_fwd);
   assign cd_in  = decrypt_ff ? cd_rotr(cd_ff, ROT_TWO[RoundBits'(Rounds-1) - round_ff])
                              : cd_fwd;
   assign f_out  = round_f(r_ff, subkey);
   assign last_round = (round_ff == RoundBits'(Rounds-1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) state_in = ST_RUN;
         end
         ST_RUN: begin
            if (last_round) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         key_ff     <= '0;
         decrypt_ff <= 1'b0;
         counter_ff <= '0;
         round_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            case (csr_index)
               CSR_CIPHER_KEY: begin
                  key_ff     <= csr_wdata;
                  counter_ff <= '0;
               end
               CSR_DECRYPT_MODE: decrypt_ff <= csr_wdata[0];
               default: ;
            endcase
         end else if (req_take && req_func == FUNC_COUNTER) begin
            counter_ff <= counter_ff + 1'b1;
         end
         if (req_take) begin
            round_ff <= '0;
         end else if (state_ff == ST_RUN) begin
            round_ff <= round_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         l_ff  <= ip_blk[BlockWidth-1:HalfWidth];
         r_ff  <= ip_blk[HalfWidth-1:0];
         cd_ff <= pc1_perm(key_ff);
      end else if (state_ff == ST_RUN) begin
         l_ff  <= r_ff;
         r_ff  <= l_ff ^ f_out;
         cd_ff <= cd_in;
         if (last_round) begin
            out_ff <= fp_perm({l_ff ^ f_out, r_ff});
         end
      end
   end

endmodule

// ===== hdl/dcm_checker.sv =====
module dcm_checker
   import dcm_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [BlockWidth-1:0] rsp_block_out
);

   // held result stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_block_out))
      else $error("result changed while stalled");

   // the rounds take time, so no result right after an item
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !rsp_valid && req_stall)
      else $error("result or ready right after an item");

   // one item at a time
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("ready while a result waits");

   // a taken result frees the input side
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall |=> !rsp_valid && !req_stall)
      else $error("block stuck after result taken");

endmodule

bind des_counter_mode_generator dcm_checker u_dcm_checker (.*);
